// ===== hw/rtl/gssa_pkg.sv =====
package gssa_pkg;

	// Window geometry and datapath widths.
	localparam int WINDOW     = 10;
	localparam int SPEED_BITS = 32;
	localparam int COUNT_W    = $clog2(WINDOW + 1);
	localparam int SLOT_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int SUM_W      = SPEED_BITS + COUNT_W;

	// Divider: a few quotient bits per cycle over the padded window sum.
	localparam int DIV_BITS   = 6;
	localparam int DIV_CYCLES = (SUM_W + DIV_BITS - 1) / DIV_BITS;
	localparam int DVD_W      = DIV_CYCLES * DIV_BITS;
	localparam int DIV_CNT_W  = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

	// Saturation test: cursor * 1000 against render * (1000 + margin).
	localparam int MARGIN_W     = 12;
	localparam int MARGIN_RESET = 300;
	localparam int PERMILLE     = 1000;
	localparam int PERMILLE_W   = 10;
	localparam int FACTOR_W     = MARGIN_W + 1;
	localparam int PROD_A_W     = SPEED_BITS + PERMILLE_W;
	localparam int PROD_B_W     = SPEED_BITS + FACTOR_W;

	// Stream payload widths.
	localparam int FIELD_W     = 32;
	localparam int IN_TDATA_W  = 5 * FIELD_W;
	localparam int OUT_TDATA_W = ((3 * FIELD_W + 1 + 7) / 8) * 8;

	// Controls shared by the three averaging lanes.
	typedef struct packed {
		logic              clear;
		logic              push;
		logic              full;
		logic [SLOT_W-1:0] slot;
		logic              div_step;
		logic [COUNT_W-1:0] divisor;
	} lane_ctrl_t;

endpackage

// ===== hw/rtl/gssa_sat.sv =====
module gssa_sat (
	input  logic                                clk,
	input  logic                                en,
	input  logic [gssa_pkg::SPEED_BITS-1:0]     cursor,
	input  logic [gssa_pkg::SPEED_BITS-1:0]     render,
	input  logic [gssa_pkg::MARGIN_W-1:0]       margin,
	output logic                                saturated
);

	logic [gssa_pkg::PROD_A_W-1:0] prod_a_q;
	logic [gssa_pkg::PROD_B_W-1:0] prod_b_q;
	logic [gssa_pkg::FACTOR_W-1:0] factor;

	// Render speed is scaled by one thousand plus the margin.
	assign factor = gssa_pkg::FACTOR_W'(gssa_pkg::PERMILLE) + {1'b0, margin};

	// Both products are registered before the comparison.
	always_ff @(posedge clk) begin
		if (en) begin
			prod_a_q <= gssa_pkg::PROD_A_W'(cursor) *
				gssa_pkg::PROD_A_W'(gssa_pkg::PERMILLE);
			prod_b_q <= gssa_pkg::PROD_B_W'(render) * gssa_pkg::PROD_B_W'(factor);
		end
	end

	// The sample is saturated when the scaled cursor speed is strictly larger.
	assign saturated = gssa_pkg::PROD_B_W'(prod_a_q) > prod_b_q;

endmodule

// ===== hw/rtl/gssa_lane.sv =====
module gssa_lane (
	input  logic                            clk,
	input  logic                            arst_n,
	input  gssa_pkg::lane_ctrl_t            ctrl,
	input  logic [gssa_pkg::SPEED_BITS-1:0] sample,
	output logic [gssa_pkg::SPEED_BITS-1:0] mean
);

	logic [gssa_pkg::SPEED_BITS-1:0] win_q [gssa_pkg::WINDOW];
	logic [gssa_pkg::SUM_W-1:0]      sum_q;
	logic [gssa_pkg::SUM_W-1:0]      oldest;
	logic [gssa_pkg::SUM_W-1:0]      sum_next;
	logic [gssa_pkg::DVD_W-1:0]      dvd_q;
	logic [gssa_pkg::COUNT_W-1:0]    rem_q;
	logic [gssa_pkg::SPEED_BITS-1:0] quo_q;
	logic [gssa_pkg::DVD_W-1:0]      dvd_next;
	logic [gssa_pkg::COUNT_W-1:0]    rem_next;
	logic [gssa_pkg::SPEED_BITS-1:0] quo_next;

	// Running sum: drop the oldest entry once the window is full, add the new one.
	always_comb begin
		oldest   = ctrl.full ? gssa_pkg::SUM_W'(win_q[ctrl.slot]) : '0;
		sum_next = sum_q - oldest + gssa_pkg::SUM_W'(sample);
	end

	// Window storage holds no reset value; a slot is read only after it is written.
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			win_q[ctrl.slot] <= sample;
		end
	end

	// Window sum register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctrl.clear) begin
			sum_q <= '0;
		end else if (ctrl.push) begin
			sum_q <= sum_next;
		end
	end

	// Restoring division by the sample count, several quotient bits per cycle.
	always_comb begin
		logic [gssa_pkg::COUNT_W:0] cand;
		rem_next = rem_q;
		dvd_next = dvd_q;
		quo_next = quo_q;
		for (int i = 0; i < gssa_pkg::DIV_BITS; i++) begin
			cand     = {rem_next, dvd_next[gssa_pkg::DVD_W-1]};
			dvd_next = {dvd_next[gssa_pkg::DVD_W-2:0], 1'b0};
			if (cand >= {1'b0, ctrl.divisor}) begin
				cand     = cand - {1'b0, ctrl.divisor};
				quo_next = {quo_next[gssa_pkg::SPEED_BITS-2:0], 1'b1};
			end else begin
				quo_next = {quo_next[gssa_pkg::SPEED_BITS-2:0], 1'b0};
			end
			rem_next = cand[gssa_pkg::COUNT_W-1:0];
		end
	end

	// Dividend and partial remainder are loaded with the updated sum on a push.
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			dvd_q <= gssa_pkg::DVD_W'(sum_next);
			rem_q <= '0;
		end else if (ctrl.div_step) begin
			dvd_q <= dvd_next;
			rem_q <= rem_next;
		end
	end

	// The quotient register doubles as the cached mean; the upper quotient bits
	// are always zero, so keeping the low bits is exact.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_q <= '0;
		end else if (ctrl.div_step) begin
			quo_q <= quo_next;
		end
	end

	assign mean = quo_q;

endmodule

// ===== hw/rtl/gated_stroke_speed_averager_unit.sv =====
// Channel   Direction  Payload
// s_*       in         tuser: mode; tdata: cursor, render, frame rate, preset id, size
// m_*       out        tuser: ignored; tdata: saturated, three cached means
// cfg_*     in         saturation margin in thousandths, 12 bits
//
// A clear item or an ignored sample goes from acceptance straight to ST_EMIT and the output register.
// A non-saturated sample passes ST_MUL, ST_CMP and ST_EMIT; a saturated one also passes ST_DIV,
// where the shared-count divider in each lane produces six quotient bits a cycle.
// One item is in work at a time; a result waits in the output register while the
// next item is taken. Reset (arst_n, asynchronous) empties the windows, zeroes the
// cached means and loads the margin with 300.
module gated_stroke_speed_averager_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	// Input stream.
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic                               s_tuser,  // mode
	// cursor_speed, render_speed, frame_rate, preset_id, preset_size
	input  logic [gssa_pkg::IN_TDATA_W-1:0]    s_tdata,
	// Output stream.
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic                               m_tuser,  // ignored
	// saturated, mean_cursor_speed, mean_render_speed, mean_frame_rate, zero pad
	output logic [gssa_pkg::OUT_TDATA_W-1:0]   m_tdata,
	// Configuration.
	input  logic                               cfg_wr_en,
	input  logic [gssa_pkg::MARGIN_W-1:0]      cfg_wr_data
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_CMP  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	localparam int FW = gssa_pkg::FIELD_W;

	logic [2:0]                        state_q;
	logic [gssa_pkg::MARGIN_W-1:0]     margin_q;
	logic [gssa_pkg::SPEED_BITS-1:0]   cursor_q;
	logic [gssa_pkg::SPEED_BITS-1:0]   render_q;
	logic [gssa_pkg::SPEED_BITS-1:0]   frame_q;
	logic [FW-1:0]                     preset_id_q;
	logic [FW-1:0]                     preset_size_q;
	logic                              preset_known_q;
	logic                              last_sat_q;
	logic                              ignored_q;
	logic [gssa_pkg::COUNT_W-1:0]      count_q;
	logic [gssa_pkg::SLOT_W-1:0]       slot_q;
	logic [gssa_pkg::DIV_CNT_W-1:0]    div_cnt_q;
	logic                              m_tvalid_q;
	logic                              m_tuser_q;
	logic [gssa_pkg::OUT_TDATA_W-1:0]  m_tdata_q;

	logic                              accept;
	logic                              in_mode;
	logic [FW-1:0]                     in_cursor;
	logic [FW-1:0]                     in_render;
	logic [FW-1:0]                     in_frame;
	logic [FW-1:0]                     in_pid;
	logic [FW-1:0]                     in_psize;
	logic                              in_zero;
	logic                              preset_change;
	logic                              saturated;
	logic                              out_free;
	gssa_pkg::lane_ctrl_t              ctrl;
	logic [gssa_pkg::SPEED_BITS-1:0]   mean_cursor;
	logic [gssa_pkg::SPEED_BITS-1:0]   mean_render;
	logic [gssa_pkg::SPEED_BITS-1:0]   mean_frame;

	// Input unpacking and the decisions made at acceptance.
	assign accept        = s_tvalid && s_tready;
	assign s_tready      = (state_q == ST_IDLE);
	assign in_mode       = s_tuser;
	assign in_cursor     = s_tdata[FW-1:0];
	assign in_render     = s_tdata[2*FW-1:FW];
	assign in_frame      = s_tdata[3*FW-1:2*FW];
	assign in_pid        = s_tdata[4*FW-1:3*FW];
	assign in_psize      = s_tdata[5*FW-1:4*FW];
	assign in_zero       = (in_cursor == '0) || (in_render == '0);
	assign preset_change = !(preset_known_q && (preset_id_q == in_pid) &&
		(preset_size_q == in_psize));
	assign out_free      = !m_tvalid_q || m_tready;

	// Lane controls: a clear item or a preset change on a non-zero sample empties the windows.
	always_comb begin
		ctrl.clear    = accept && (in_mode || (!in_zero && preset_change));
		ctrl.push     = (state_q == ST_CMP) && saturated;
		ctrl.full     = (count_q == gssa_pkg::COUNT_W'(gssa_pkg::WINDOW));
		ctrl.slot     = slot_q;
		ctrl.div_step = (state_q == ST_DIV);
		ctrl.divisor  = count_q;
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q <= gssa_pkg::MARGIN_W'(gssa_pkg::MARGIN_RESET);
		end else if (cfg_wr_en) begin
			margin_q <= cfg_wr_data;
		end
	end

	// Sample holding registers for the multiply and push steps.
	always_ff @(posedge clk) begin
		if (accept) begin
			cursor_q <= in_cursor;
			render_q <= in_render;
			frame_q  <= in_frame;
		end
	end

	// Sequencer, preset memory, window count and write slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			preset_id_q    <= '0;
			preset_size_q  <= '0;
			preset_known_q <= 1'b0;
			last_sat_q     <= 1'b0;
			ignored_q      <= 1'b0;
			count_q        <= '0;
			slot_q         <= '0;
			div_cnt_q      <= '0;
		end else begin
			if (ctrl.clear) begin
				count_q <= '0;
				slot_q  <= '0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_mode) begin
							ignored_q <= 1'b0;
							state_q   <= ST_EMIT;
						end else if (in_zero) begin
							ignored_q <= 1'b1;
							state_q   <= ST_EMIT;
						end else begin
							ignored_q <= 1'b0;
							if (preset_change) begin
								preset_id_q    <= in_pid;
								preset_size_q  <= in_psize;
								preset_known_q <= 1'b1;
							end
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					last_sat_q <= saturated;
					if (saturated) begin
						if (slot_q == gssa_pkg::SLOT_W'(gssa_pkg::WINDOW - 1)) begin
							slot_q <= '0;
						end else begin
							slot_q <= slot_q + gssa_pkg::SLOT_W'(1);
						end
						if (!ctrl.full) begin
							count_q <= count_q + gssa_pkg::COUNT_W'(1);
						end
						div_cnt_q <= '0;
						state_q   <= ST_DIV;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + gssa_pkg::DIV_CNT_W'(1);
					if (div_cnt_q == gssa_pkg::DIV_CNT_W'(gssa_pkg::DIV_CYCLES - 1)) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Saturation test.
	gssa_sat u_sat (
		.clk       (clk),
		.en        (state_q == ST_MUL),
		.cursor    (cursor_q),
		.render    (render_q),
		.margin    (margin_q),
		.saturated (saturated)
	);

	// Three averaging lanes working side by side.
	gssa_lane u_lane_cursor (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.sample (cursor_q),
		.mean   (mean_cursor)
	);

	gssa_lane u_lane_render (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.sample (render_q),
		.mean   (mean_render)
	);

	gssa_lane u_lane_frame (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.sample (frame_q),
		.mean   (mean_frame)
	);

	// Merging stage: the output register gathers the lane means and the verdicts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if ((state_q == ST_EMIT) && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_EMIT) && out_free) begin
			m_tuser_q <= ignored_q;
			m_tdata_q <= gssa_pkg::OUT_TDATA_W'({FW'(mean_frame), FW'(mean_render),
				FW'(mean_cursor), last_sat_q});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_tuser_q;
	assign m_tdata  = m_tdata_q;

endmodule
